@@ rtl/hsv_to_rgb_with_dim_curve_unit_defines.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_WITH_DIM_CURVE_UNIT_DEFINES_SVH
`define HSV_TO_RGB_WITH_DIM_CURVE_UNIT_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define HRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a condition that must hold whenever a trigger is seen.
`define HRD_ASSERT_WHEN(label, trig, cond, msg) \
	`HRD_ASSERT(label, (trig) |-> (cond), msg)

`endif

@@ rtl/hrd_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB package
// Dimming curve, sector codes, divide-by-60 constants and stage types.
// ----------------------------------------------------------------------------
package hrd_pkg;

	typedef logic [2:0] sector_t;

	localparam sector_t SECT_RED_UP_GREEN   = 3'd0;
	localparam sector_t SECT_GREEN_DOWN_RED = 3'd1;
	localparam sector_t SECT_GREEN_UP_BLUE  = 3'd2;
	localparam sector_t SECT_BLUE_DOWN_GRN  = 3'd3;
	localparam sector_t SECT_BLUE_UP_RED    = 3'd4;
	localparam sector_t SECT_RED_DOWN_BLUE  = 3'd5;

	localparam logic [8:0] HUE_MAX    = 9'd359;
	localparam logic [5:0] SECTOR_DEG = 6'd60;
	localparam logic [7:0] FULL_SCALE = 8'hFF;

	// floor(p / 60) == (p * 17477) >> 20 for every p below 15360
	localparam logic [14:0] RECIP_60    = 15'd17477;
	localparam int          RECIP_SHIFT = 20;

	localparam logic [7:0] DIM_ROM [256] = '{
		8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
		8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
		8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
		8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
		8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
		8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
		8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
		8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
		8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
		8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
		8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
		8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
		8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
		8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
		8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
		8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
		8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
		8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
		8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
		8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
		8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
		8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
		8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
		8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
		8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
		8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
		8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
		8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
		8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
		8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
		8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
	};

	// Stage 2 word: levels and ramp fraction ready for the ramp multiply
	typedef struct packed {
		logic [7:0] val;
		logic [7:0] base;
		logic [5:0] frac;
		sector_t    sector;
		logic       grey;
	} hrd_mid_t;

	// Stage 4 word: ramp step divided by 60, levels alongside
	typedef struct packed {
		logic [7:0] quot;
		logic [7:0] val;
		logic [7:0] base;
		sector_t    sector;
		logic       grey;
	} hrd_ramp_t;

	// Per-stage advance enables from the top-level flow control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} hrd_adv_t;

endpackage

@@ rtl/hrd_front.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Stage 1: dimming lookups and hue sector split. Stage 2: base level product.
// ----------------------------------------------------------------------------
module hrd_front (
	input  logic             clk,
	input  hrd_pkg::hrd_adv_t adv,
	input  logic [8:0]       hue_degrees,
	input  logic [7:0]       saturation_in,
	input  logic [7:0]       brightness_in,
	output hrd_pkg::hrd_mid_t mid_s2
);
	import hrd_pkg::*;

	logic [8:0]  hue_sat;
	sector_t     sector;
	logic [8:0]  sector_start;
	logic [8:0]  pos_wide;
	logic [7:0]  val_s1;
	logic [7:0]  inv_s1;
	sector_t     sector_s1;
	logic [5:0]  pos_s1;
	logic [15:0] base_prod;
	logic        ramp_down;

	// Clamp out-of-range hue into the last sector
	assign hue_sat = (hue_degrees > HUE_MAX) ? HUE_MAX : hue_degrees;

	always_comb begin
		if (hue_sat >= 9'd300) begin
			sector       = SECT_RED_DOWN_BLUE;
			sector_start = 9'd300;
		end else if (hue_sat >= 9'd240) begin
			sector       = SECT_BLUE_UP_RED;
			sector_start = 9'd240;
		end else if (hue_sat >= 9'd180) begin
			sector       = SECT_BLUE_DOWN_GRN;
			sector_start = 9'd180;
		end else if (hue_sat >= 9'd120) begin
			sector       = SECT_GREEN_UP_BLUE;
			sector_start = 9'd120;
		end else if (hue_sat >= 9'd60) begin
			sector       = SECT_GREEN_DOWN_RED;
			sector_start = 9'd60;
		end else begin
			sector       = SECT_RED_UP_GREEN;
			sector_start = 9'd0;
		end
	end

	assign pos_wide = hue_sat - sector_start;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			val_s1    <= DIM_ROM[brightness_in];
			inv_s1    <= DIM_ROM[FULL_SCALE - saturation_in];
			sector_s1 <= sector;
			pos_s1    <= pos_wide[5:0];
		end
	end

	// inv_s1 is the dimming curve value of 255 minus the saturation
	assign base_prod = 16'(inv_s1) * 16'(val_s1);
	assign ramp_down = (sector_s1 == SECT_GREEN_DOWN_RED) ||
	                   (sector_s1 == SECT_BLUE_DOWN_GRN)  ||
	                   (sector_s1 == SECT_RED_DOWN_BLUE);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			mid_s2.val    <= val_s1;
			mid_s2.base   <= base_prod[15:8];
			mid_s2.frac   <= ramp_down ? (SECTOR_DEG - pos_s1) : pos_s1;
			mid_s2.sector <= sector_s1;
			mid_s2.grey   <= (inv_s1 == FULL_SCALE);
		end
	end

endmodule

@@ rtl/hrd_ramp.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB ramp
// Stage 3: span times fraction. Stage 4: reciprocal divide by 60.
// ----------------------------------------------------------------------------
module hrd_ramp (
	input  logic              clk,
	input  hrd_pkg::hrd_adv_t  adv,
	input  hrd_pkg::hrd_mid_t  mid_s2,
	output hrd_pkg::hrd_ramp_t ramp_s4
);
	import hrd_pkg::*;

	logic [7:0]  span;
	logic [13:0] prod_s3;
	logic [7:0]  val_s3;
	logic [7:0]  base_s3;
	sector_t     sector_s3;
	logic        grey_s3;
	logic [28:0] recip_prod;

	// base never exceeds val, so the span fits eight bits
	assign span = mid_s2.val - mid_s2.base;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			prod_s3   <= 14'(span) * 14'(mid_s2.frac);
			val_s3    <= mid_s2.val;
			base_s3   <= mid_s2.base;
			sector_s3 <= mid_s2.sector;
			grey_s3   <= mid_s2.grey;
		end
	end

	assign recip_prod = 29'(prod_s3) * 29'(RECIP_60);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			ramp_s4.quot   <= recip_prod[RECIP_SHIFT +: 8];
			ramp_s4.val    <= val_s3;
			ramp_s4.base   <= base_s3;
			ramp_s4.sector <= sector_s3;
			ramp_s4.grey   <= grey_s3;
		end
	end

endmodule

@@ rtl/hsv_to_rgb_with_dim_curve_unit.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter with dimming curve
// An accepted input word moves through ranks s1, s2, s3, s4, s5 to the output.
// Throughput: one word per cycle when not stalled; each stage holds only while
// the stage after it is full and blocked, so bubbles close up on output stall.
// Reset: arst_n clears all stage valid bits at once; the data path is not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_with_dim_curve_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [8:0] hue_degrees,
	input  logic [7:0] saturation_in,
	input  logic [7:0] brightness_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);
	import hrd_pkg::*;

	`include "hsv_to_rgb_with_dim_curve_unit_defines.svh"

	// Stage valid flags, one per register rank
	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      valid_s4;
	logic      valid_s5;
	logic      adv_s5;
	logic      pipe_full;
	logic      grey_load;
	hrd_adv_t  adv;
	hrd_mid_t  mid_s2;
	hrd_ramp_t ramp_s4;
	logic [7:0] ramp_lvl;
	logic [7:0] red_s5;
	logic [7:0] green_s5;
	logic [7:0] blue_s5;

	// A stage may load when it is empty or its current word moves on
	assign adv_s5 = !valid_s5 || !out_stall;
	assign adv.s4 = !valid_s4 || adv_s5;
	assign adv.s3 = !valid_s3 || adv.s4;
	assign adv.s2 = !valid_s2 || adv.s3;
	assign adv.s1 = !valid_s1 || adv.s2;

	// Hold the input only when every rank is full and the output is blocked
	assign in_stall = !adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv.s1) begin
				valid_s1 <= in_valid;
			end
			if (adv.s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv.s4) begin
				valid_s4 <= valid_s3;
			end
			if (adv_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stages 1 and 2: dimming curve, sector split, base level
	hrd_front u_front (
		.clk           (clk),
		.adv           (adv),
		.hue_degrees   (hue_degrees),
		.saturation_in (saturation_in),
		.brightness_in (brightness_in),
		.mid_s2        (mid_s2)
	);

	// Stages 3 and 4: ramp step and divide by 60
	hrd_ramp u_ramp (
		.clk     (clk),
		.adv     (adv),
		.mid_s2  (mid_s2),
		.ramp_s4 (ramp_s4)
	);

	// Stage 5: add the base back and steer levels to channels
	assign ramp_lvl = ramp_s4.quot + ramp_s4.base;

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			if (ramp_s4.grey) begin
				// Zero saturation: grey at the dimmed value, hue ignored
				red_s5   <= ramp_s4.val;
				green_s5 <= ramp_s4.val;
				blue_s5  <= ramp_s4.val;
			end else begin
				case (ramp_s4.sector)
					SECT_RED_UP_GREEN: begin
						red_s5   <= ramp_s4.val;
						green_s5 <= ramp_lvl;
						blue_s5  <= ramp_s4.base;
					end
					SECT_GREEN_DOWN_RED: begin
						red_s5   <= ramp_lvl;
						green_s5 <= ramp_s4.val;
						blue_s5  <= ramp_s4.base;
					end
					SECT_GREEN_UP_BLUE: begin
						red_s5   <= ramp_s4.base;
						green_s5 <= ramp_s4.val;
						blue_s5  <= ramp_lvl;
					end
					SECT_BLUE_DOWN_GRN: begin
						red_s5   <= ramp_s4.base;
						green_s5 <= ramp_lvl;
						blue_s5  <= ramp_s4.val;
					end
					SECT_BLUE_UP_RED: begin
						red_s5   <= ramp_lvl;
						green_s5 <= ramp_s4.base;
						blue_s5  <= ramp_s4.val;
					end
					default: begin
						red_s5   <= ramp_s4.val;
						green_s5 <= ramp_s4.base;
						blue_s5  <= ramp_lvl;
					end
				endcase
			end
		end
	end

	assign out_valid = valid_s5;
	assign red_out   = red_s5;
	assign green_out = green_s5;
	assign blue_out  = blue_s5;

	// Every rank holds a word; a grey word moves into the output rank
	assign pipe_full = valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5;
	assign grey_load = valid_s4 && adv_s5 && ramp_s4.grey;

	// Input is only held back when the whole pipe is full behind a blocked output
	`HRD_ASSERT_WHEN(a_stall_full, in_stall, pipe_full && out_stall, "input held with room")
	// An accepted word lands in the first rank
	`HRD_ASSERT(a_accept_lands, (in_valid && !in_stall) |=> valid_s1, "accepted word lost")
	// A grey word leaves with all three channels equal
	`HRD_ASSERT(a_grey_equal, grey_load |=> (green_out == red_out && blue_out == red_out), "bad grey")

endmodule
